/* design/mixed_radix_tree_neighbour_index_macros.svh */
// Assertion macros for the mixed-radix tree neighbour index.
// Included by the top level; the bodies compile away when SYNTH is defined.
`ifndef MIXED_RADIX_TREE_NEIGHBOUR_INDEX_MACROS_SVH
`define MIXED_RADIX_TREE_NEIGHBOUR_INDEX_MACROS_SVH
`ifndef SYNTH
`define MRTNI_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrtni assertion failed");
`define MRTNI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrtni assertion failed");
`else
`define MRTNI_ASSERT_NOW(name, ante, cons)
`define MRTNI_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* design/mrtni_pkg.sv */
// Package of the mixed-radix tree neighbour index: widths, register indexes,
// saturating level-table arithmetic and the short division step.
// Depends on nothing.
`default_nettype none
package mrtni_pkg;

    localparam int RANK_W     = 24;
    localparam int VAL_W      = RANK_W + 1;
    localparam int FAN_W      = 5;
    localparam int LVL_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int FAN_REGS   = 6;
    localparam int LEVEL_CAP  = 7;
    localparam int MIN_LEVELS = 2;
    localparam int DIV_CHUNK  = 8;
    localparam int IN_W       = 24;
    localparam int OUT_W      = 64;

    localparam int MAX_LEVELS_DEF = 7;
    localparam int RANK_BITS_DEF  = 24;
    localparam int MAX_FANOUT_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FANOUT_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FANOUT_LAST  = 3'd6;

    localparam logic [LVL_W-1:0] RESET_LEVEL_COUNT = 3'd3;
    localparam logic [FAN_W-1:0] RESET_FANOUT      = 5'd2;

    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [FAN_W-1:0]  t_fan;
    typedef logic [RANK_W-1:0] t_rank;

    // Any level start or size at or above this value lies outside every tree.
    localparam t_val BIG = t_val'(1) << RANK_W;

    typedef struct packed {
        logic [FAN_W-1:0]     rem;
        logic [DIV_CHUNK-1:0] q;
    } t_div_res;

    function automatic t_val sat_add(input t_val a, input t_val b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, BIG}) begin
            return BIG;
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic t_val sat_mul(input t_val a, input t_fan f);
        logic [VAL_W+FAN_W-1:0] p;
        p = (VAL_W + FAN_W)'(a) * (VAL_W + FAN_W)'(f);
        if (p >= (VAL_W + FAN_W)'(BIG)) begin
            return BIG;
        end
        return p[VAL_W-1:0];
    endfunction

    // Eight steps of restoring long division by a small divisor.
    function automatic t_div_res div_step8(input t_fan rem_in,
                                           input logic [DIV_CHUNK-1:0] bits,
                                           input t_fan d);
        t_div_res         res;
        logic [FAN_W:0]   t;
        t_fan             rem;
        rem = rem_in;
        res = '0;
        for (int k = DIV_CHUNK - 1; k >= 0; k--) begin
            t = {rem, bits[k]};
            if (t >= {1'b0, d}) begin
                res.q[k] = 1'b1;
                rem      = FAN_W'(t - {1'b0, d});
            end else begin
                res.q[k] = 1'b0;
                rem      = t[FAN_W-1:0];
            end
        end
        res.rem = rem;
        return res;
    endfunction

endpackage
`default_nettype wire

/* design/mixed_radix_tree_neighbour_index.sv */
// A request passes through the registered stages A to F; stage F is the output register.
// Throughput: one request per cycle when the output and the table rebuild do not stall;
// the quotient is built eight bits per stage. After reset and after every register
// write the input is held off while the level table is rebuilt, one level per cycle.
// Reset is synchronous and active low; registers return to three levels, fan-out two.
// Depends on mrtni_pkg and mixed_radix_tree_neighbour_index_macros.svh.
`default_nettype none
`include "mixed_radix_tree_neighbour_index_macros.svh"
module mixed_radix_tree_neighbour_index #(
    parameter int MAX_LEVELS = mrtni_pkg::MAX_LEVELS_DEF,
    parameter int RANK_BITS  = mrtni_pkg::RANK_BITS_DEF,
    parameter int MAX_FANOUT = mrtni_pkg::MAX_FANOUT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [mrtni_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mrtni_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // node_rank[23:0]
    input  wire logic [mrtni_pkg::IN_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // node_level[2:0], has_parent[3], parent_rank[27:4], first_child[51:28],
    // child_count[56:52], status[57], zero[63:58]
    output logic [mrtni_pkg::OUT_W-1:0]           m_tdata
);

    localparam int LVL_N   = (MAX_LEVELS < mrtni_pkg::LEVEL_CAP) ?
                             MAX_LEVELS : mrtni_pkg::LEVEL_CAP;
    localparam int RB      = (RANK_BITS < mrtni_pkg::RANK_W) ? RANK_BITS : mrtni_pkg::RANK_W;
    localparam int VW      = mrtni_pkg::VAL_W;
    localparam int RW      = mrtni_pkg::RANK_W;
    localparam int FW      = mrtni_pkg::FAN_W;
    localparam int LW      = mrtni_pkg::LVL_W;
    localparam int CH      = mrtni_pkg::DIV_CHUNK;
    localparam int STEP_W  = $clog2(LVL_N + 2);
    localparam int IDX_W   = $clog2(LVL_N + 1);
    localparam int PROD_W  = RW + FW;
    localparam int FIRST_W = PROD_W + 1;
    localparam int PAD_W   = mrtni_pkg::OUT_W - (LW + 1 + RW + RW + FW + 1);
    localparam logic [VW-1:0] LIM_CAP = VW'(1) << RB;

    // Configuration registers
    logic [LW-1:0] r_level_count;
    logic [FW-1:0] r_fanout [0:mrtni_pkg::FAN_REGS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= mrtni_pkg::RESET_LEVEL_COUNT;
            for (int i = 0; i < mrtni_pkg::FAN_REGS; i++) begin
                r_fanout[i] <= mrtni_pkg::RESET_FANOUT;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mrtni_pkg::CFG_LEVEL_COUNT: begin
                    r_level_count <= i_cfg_data[LW-1:0];
                end
                default: begin
                    if (i_cfg_index >= mrtni_pkg::CFG_FANOUT_FIRST &&
                        i_cfg_index <= mrtni_pkg::CFG_FANOUT_LAST) begin
                        r_fanout[i_cfg_index - mrtni_pkg::CFG_FANOUT_FIRST] <= i_cfg_data;
                    end
                end
            endcase
        end
    end

    // Effective fan-outs and level count
    logic [FW-1:0] w_fan [0:LVL_N-1];
    logic [LW-1:0] w_levels;

    for (genvar g = 0; g < LVL_N; g++) begin : g_fan
        if (g < mrtni_pkg::FAN_REGS) begin : g_reg
            always_comb begin
                if (r_fanout[g] == '0) begin
                    w_fan[g] = FW'(1);
                end else if (int'(r_fanout[g]) > MAX_FANOUT) begin
                    w_fan[g] = FW'(MAX_FANOUT);
                end else begin
                    w_fan[g] = r_fanout[g];
                end
            end
        end else begin : g_one
            assign w_fan[g] = FW'(1);
        end
    end

    always_comb begin
        if (int'(r_level_count) < mrtni_pkg::MIN_LEVELS) begin
            w_levels = LW'(mrtni_pkg::MIN_LEVELS);
        end else if (int'(r_level_count) > LVL_N) begin
            w_levels = LW'(LVL_N);
        end else begin
            w_levels = r_level_count;
        end
    end

    // Level table rebuild: one running sum and one product per cycle
    logic              r_seq_busy;
    logic [STEP_W-1:0] r_step;
    logic [VW-1:0]     r_size;
    logic [VW-1:0]     r_last;
    logic [VW-1:0]     r_total;
    logic [VW-1:0]     r_lim;
    logic [FW-1:0]     r_fan_sh [0:LVL_N-1];
    logic [VW-1:0]     r_start  [0:LVL_N];
    logic [VW-1:0]     n_seq_start;

    assign n_seq_start = mrtni_pkg::sat_add(r_last, r_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_seq_busy <= 1'b1;
            r_step     <= '0;
        end else if (r_seq_busy) begin
            if (r_step == '0) begin
                r_fan_sh   <= w_fan;
                r_size     <= VW'(1);
                r_last     <= '0;
                r_start[0] <= '0;
                r_step     <= STEP_W'(1);
            end else if (r_step <= STEP_W'(LVL_N)) begin
                r_start[r_step[IDX_W-1:0]] <= n_seq_start;
                r_last <= n_seq_start;
                r_size <= mrtni_pkg::sat_mul(r_size, r_fan_sh[0]);
                for (int i = 0; i < LVL_N - 1; i++) begin
                    r_fan_sh[i] <= r_fan_sh[i+1];
                end
                if (r_step == STEP_W'(w_levels)) begin
                    r_total <= n_seq_start;
                end
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_lim      <= (r_total < LIM_CAP) ? r_total : LIM_CAP;
                r_seq_busy <= 1'b0;
            end
        end
    end

    // Ready chain
    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d, w_rdy_e, w_rdy_f;
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v;

    assign w_rdy_f  = !r_f_v || m_tready;
    assign w_rdy_e  = !r_e_v || w_rdy_f;
    assign w_rdy_d  = !r_d_v || w_rdy_e;
    assign w_rdy_c  = !r_c_v || w_rdy_d;
    assign w_rdy_b  = !r_b_v || w_rdy_c;
    assign w_rdy_a  = !r_a_v || w_rdy_b;
    assign s_tready = w_rdy_a && !r_seq_busy;

    // Stage A: level search and range check
    logic [RW-1:0]    w_rank;
    logic [LVL_N-1:0] w_ge;
    logic [LVL_N-1:0] n_a_oh;
    logic [LW-1:0]    n_a_lvl;
    logic             n_a_kids;
    logic [RW-1:0]    r_a_rank;
    logic [LVL_N-1:0] r_a_oh;
    logic [LW-1:0]    r_a_lvl;
    logic             r_a_oor;
    logic             r_a_kids;

    assign w_rank = s_tdata[RW-1:0];

    always_comb begin
        w_ge[0] = 1'b1;
        for (int i = 1; i < LVL_N; i++) begin
            w_ge[i] = (LW'(i) < w_levels) && (r_start[i] <= {1'b0, w_rank});
        end
        for (int i = 0; i < LVL_N - 1; i++) begin
            n_a_oh[i] = w_ge[i] && !w_ge[i+1];
        end
        n_a_oh[LVL_N-1] = w_ge[LVL_N-1];
        n_a_lvl = '0;
        for (int i = 0; i < LVL_N; i++) begin
            if (w_ge[i]) begin
                n_a_lvl = LW'(i);
            end
        end
        n_a_kids = ({1'b0, n_a_lvl} + (LW + 1)'(1)) < {1'b0, w_levels};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_rdy_a) begin
            r_a_v    <= s_tvalid && s_tready;
            r_a_rank <= w_rank;
            r_a_oh   <= n_a_oh;
            r_a_lvl  <= n_a_lvl;
            r_a_oor  <= ({1'b0, w_rank} >= r_lim);
            r_a_kids <= n_a_kids;
        end
    end

    // Stage B: level table selection and offset within the level
    logic [VW-1:0] n_b_prev, n_b_cur, n_b_next;
    logic [FW-1:0] n_b_fan_up, n_b_fan_dn;
    logic [RW-1:0] r_b_off;
    logic [VW-1:0] r_b_prev, r_b_next;
    logic [FW-1:0] r_b_fan_up, r_b_fan_dn;
    logic [LW-1:0] r_b_lvl;
    logic          r_b_oor, r_b_kids;

    always_comb begin
        n_b_prev   = '0;
        n_b_cur    = '0;
        n_b_next   = '0;
        n_b_fan_up = FW'(1);
        n_b_fan_dn = '0;
        for (int i = 0; i < LVL_N; i++) begin
            if (r_a_oh[i]) begin
                n_b_cur    = n_b_cur | r_start[i];
                n_b_next   = n_b_next | r_start[i+1];
                n_b_fan_dn = n_b_fan_dn | w_fan[i];
            end
        end
        for (int i = 1; i < LVL_N; i++) begin
            if (r_a_oh[i]) begin
                n_b_prev   = n_b_prev | r_start[i-1];
                n_b_fan_up = w_fan[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_rdy_b) begin
            r_b_v      <= r_a_v;
            r_b_off    <= r_a_rank - n_b_cur[RW-1:0];
            r_b_prev   <= n_b_prev;
            r_b_next   <= n_b_next;
            r_b_fan_up <= n_b_fan_up;
            r_b_fan_dn <= n_b_fan_dn;
            r_b_lvl    <= r_a_lvl;
            r_b_oor    <= r_a_oor;
            r_b_kids   <= r_a_kids;
        end
    end

    // Stage C: child offset product and top quotient byte
    mrtni_pkg::t_div_res n_c_div;
    logic [PROD_W-1:0]   r_c_prod;
    logic [RW-1:0]       r_c_off;
    logic [CH-1:0]       r_c_q;
    logic [FW-1:0]       r_c_rem;
    logic [VW-1:0]       r_c_prev, r_c_next;
    logic [FW-1:0]       r_c_fan_up, r_c_fan_dn;
    logic [LW-1:0]       r_c_lvl;
    logic                r_c_oor, r_c_kids;

    assign n_c_div = mrtni_pkg::div_step8('0, r_b_off[RW-1 -: CH], r_b_fan_up);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_rdy_c) begin
            r_c_v      <= r_b_v;
            r_c_prod   <= PROD_W'(r_b_off) * PROD_W'(r_b_fan_dn);
            r_c_off    <= r_b_off;
            r_c_q      <= n_c_div.q;
            r_c_rem    <= n_c_div.rem;
            r_c_prev   <= r_b_prev;
            r_c_next   <= r_b_next;
            r_c_fan_up <= r_b_fan_up;
            r_c_fan_dn <= r_b_fan_dn;
            r_c_lvl    <= r_b_lvl;
            r_c_oor    <= r_b_oor;
            r_c_kids   <= r_b_kids;
        end
    end

    // Stage D: first child rank and middle quotient byte
    mrtni_pkg::t_div_res n_d_div;
    logic [FIRST_W-1:0]  r_d_first;
    logic [CH-1:0]       r_d_lo;
    logic [2*CH-1:0]     r_d_q;
    logic [FW-1:0]       r_d_rem;
    logic [VW-1:0]       r_d_prev;
    logic [FW-1:0]       r_d_fan_up, r_d_fan_dn;
    logic [LW-1:0]       r_d_lvl;
    logic                r_d_oor, r_d_kids;

    assign n_d_div = mrtni_pkg::div_step8(r_c_rem, r_c_off[RW-CH-1 -: CH], r_c_fan_up);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (w_rdy_d) begin
            r_d_v      <= r_c_v;
            r_d_first  <= FIRST_W'(r_c_next) + FIRST_W'(r_c_prod);
            r_d_lo     <= r_c_off[CH-1:0];
            r_d_q      <= {r_c_q, n_d_div.q};
            r_d_rem    <= n_d_div.rem;
            r_d_prev   <= r_c_prev;
            r_d_fan_up <= r_c_fan_up;
            r_d_fan_dn <= r_c_fan_dn;
            r_d_lvl    <= r_c_lvl;
            r_d_oor    <= r_c_oor;
            r_d_kids   <= r_c_kids;
        end
    end

    // Stage E: clip the children to the tree and finish the quotient
    mrtni_pkg::t_div_res n_e_div;
    logic [RW-1:0]       n_e_first;
    logic [FW-1:0]       n_e_count;
    logic [RW-1:0]       r_e_first;
    logic [FW-1:0]       r_e_count;
    logic [RW-1:0]       r_e_q;
    logic [VW-1:0]       r_e_prev;
    logic [LW-1:0]       r_e_lvl;
    logic                r_e_oor;

    assign n_e_div = mrtni_pkg::div_step8(r_d_rem, r_d_lo, r_d_fan_up);

    always_comb begin
        n_e_first = '0;
        n_e_count = '0;
        if (r_d_kids && (r_d_first < FIRST_W'(r_lim))) begin
            n_e_first = r_d_first[RW-1:0];
            if ((FIRST_W + 1)'(r_d_first) + (FIRST_W + 1)'(r_d_fan_dn) >
                (FIRST_W + 1)'(r_lim)) begin
                n_e_count = FW'(FIRST_W'(r_lim) - r_d_first);
            end else begin
                n_e_count = r_d_fan_dn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (w_rdy_e) begin
            r_e_v     <= r_d_v;
            r_e_first <= n_e_first;
            r_e_count <= n_e_count;
            r_e_q     <= {r_d_q, n_e_div.q};
            r_e_prev  <= r_d_prev;
            r_e_lvl   <= r_d_lvl;
            r_e_oor   <= r_d_oor;
        end
    end

    // Stage F: parent rank and result register
    logic [VW:0]   n_f_parent;
    logic [LW-1:0] r_f_level;
    logic          r_f_has_parent;
    logic [RW-1:0] r_f_parent;
    logic [RW-1:0] r_f_first;
    logic [FW-1:0] r_f_count;
    logic          r_f_status;

    assign n_f_parent = (VW + 1)'(r_e_prev) + (VW + 1)'(r_e_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_rdy_f) begin
            r_f_v <= r_e_v;
            if (r_e_oor) begin
                r_f_level      <= '0;
                r_f_has_parent <= 1'b0;
                r_f_parent     <= '0;
                r_f_first      <= '0;
                r_f_count      <= '0;
                r_f_status     <= 1'b1;
            end else begin
                r_f_level      <= r_e_lvl;
                r_f_has_parent <= (r_e_lvl != '0);
                r_f_parent     <= (r_e_lvl != '0) ? n_f_parent[RW-1:0] : '0;
                r_f_first      <= r_e_first;
                r_f_count      <= r_e_count;
                r_f_status     <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_f_v;
    assign m_tdata  = {{PAD_W{1'b0}}, r_f_status, r_f_count, r_f_first, r_f_parent,
                       r_f_has_parent, r_f_level};

    logic w_f_zero;

    assign w_f_zero = ({r_f_level, r_f_has_parent, r_f_parent, r_f_first, r_f_count} == '0);

    `MRTNI_ASSERT_NOW(a_oor_clears_fields, r_f_v && r_f_status, w_f_zero)
    `MRTNI_ASSERT_NOW(a_root_has_no_parent, r_f_v && !r_f_has_parent, {r_f_level, r_f_parent} == '0)
    `MRTNI_ASSERT_NOW(a_children_agree, r_f_v, (r_f_count == '0) == (r_f_first == '0))
    `MRTNI_ASSERT_NEXT(a_write_holds_input, i_cfg_we, !s_tready)

endmodule
`default_nettype wire

/* verif/mixed_radix_tree_neighbour_index_tb.sv */
// Self-checking testbench for mixed_radix_tree_neighbour_index: directed requests under
// reset, extreme and out-of-range register settings, then random idle and stall phases.
// Depends on mrtni_pkg and the block itself.
`timescale 1ns / 1ps
module mixed_radix_tree_neighbour_index_tb;

    localparam int LATENCY       = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 150;
    localparam int RANDOM_PHASES = 6;
    localparam longint unsigned RANK_SPAN = 64'd1 << 24;
    localparam logic [mrtni_pkg::CFG_IDX_W-1:0] CFG_UNUSED =
        mrtni_pkg::CFG_FANOUT_LAST + 3'd1;

    typedef enum logic {ROW_WRITE, ROW_REQUEST} t_row_kind;

    // Packed from the top bit down, so that it matches the low bits of m_tdata.
    typedef struct packed {
        logic                            status;
        logic [mrtni_pkg::FAN_W-1:0]     child_count;
        logic [mrtni_pkg::RANK_W-1:0]    first_child;
        logic [mrtni_pkg::RANK_W-1:0]    parent_rank;
        logic                            has_parent;
        logic [mrtni_pkg::LVL_W-1:0]     node_level;
    } t_locate;

    typedef struct {
        t_row_kind                        kind;
        logic [mrtni_pkg::CFG_IDX_W-1:0]  index;
        logic [mrtni_pkg::CFG_DATA_W-1:0] value;
        logic [mrtni_pkg::RANK_W-1:0]     rank;
        bit                               typed;
        t_locate                          want;
    } t_row;

    localparam t_locate OFF_TREE = '{status: 1'b1, default: '0};

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_we    = 1'b0;
    logic [mrtni_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [mrtni_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                             s_tvalid    = 1'b0;
    logic                             s_tready;
    logic [mrtni_pkg::IN_W-1:0]       s_tdata     = '0;
    logic                             m_tvalid;
    logic                             m_tready    = 1'b0;
    logic [mrtni_pkg::OUT_W-1:0]      m_tdata;

    logic [mrtni_pkg::LVL_W-1:0] cfg_levels;
    logic [mrtni_pkg::FAN_W-1:0] cfg_fanout [mrtni_pkg::FAN_REGS];

    t_locate pending_locations [$];
    t_row    rows [$];
    int      idle_pct     = 0;
    int      stall_pct    = 0;
    int      fail_count   = 0;
    int      results_seen = 0;
    int      settings_run = 0;
    int      cycle_count  = 0;

    mixed_radix_tree_neighbour_index u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint unsigned eff_levels();
        longint unsigned n;
        n = cfg_levels;
        if (n < mrtni_pkg::MIN_LEVELS) begin
            n = mrtni_pkg::MIN_LEVELS;
        end
        if (n > mrtni_pkg::MAX_LEVELS_DEF) begin
            n = mrtni_pkg::MAX_LEVELS_DEF;
        end
        return n;
    endfunction

    function automatic longint unsigned eff_fanout(int lvl);
        longint unsigned f;
        if (lvl >= mrtni_pkg::FAN_REGS) begin
            return 1;
        end
        f = cfg_fanout[lvl];
        if (f < 1) begin
            f = 1;
        end
        if (f > mrtni_pkg::MAX_FANOUT_DEF) begin
            f = mrtni_pkg::MAX_FANOUT_DEF;
        end
        return f;
    endfunction

    function automatic longint unsigned level_start(int lvl);
        longint unsigned s;
        longint unsigned z;
        s = 0;
        z = 1;
        for (int i = 0; i < lvl; i++) begin
            s += z;
            z *= eff_fanout(i);
        end
        return s;
    endfunction

    function automatic longint unsigned tree_span();
        longint unsigned total;
        total = level_start(int'(eff_levels()));
        return (total < RANK_SPAN) ? total : RANK_SPAN;
    endfunction

    function automatic t_locate locate(int lvl, bit hp, longint unsigned par,
                                       longint unsigned first, longint unsigned cnt);
        t_locate res;
        res             = '0;
        res.node_level  = mrtni_pkg::LVL_W'(lvl);
        res.has_parent  = hp;
        res.parent_rank = mrtni_pkg::RANK_W'(par);
        res.first_child = mrtni_pkg::RANK_W'(first);
        res.child_count = mrtni_pkg::FAN_W'(cnt);
        return res;
    endfunction

    function automatic t_locate predict_location(logic [mrtni_pkg::RANK_W-1:0] rank);
        longint unsigned r;
        longint unsigned lim;
        longint unsigned n;
        longint unsigned par;
        longint unsigned first;
        longint unsigned cnt;
        int              lvl;
        r     = rank;
        lim   = tree_span();
        n     = eff_levels();
        lvl   = 0;
        par   = 0;
        first = 0;
        cnt   = 0;
        if (r >= lim) begin
            return OFF_TREE;
        end
        for (int i = 0; i < int'(n); i++) begin
            if (level_start(i) <= r) begin
                lvl = i;
            end
        end
        if (lvl > 0) begin
            par = level_start(lvl - 1) + (r - level_start(lvl)) / eff_fanout(lvl - 1);
        end
        if (lvl + 1 < int'(n)) begin
            first = level_start(lvl + 1) + (r - level_start(lvl)) * eff_fanout(lvl);
            cnt   = eff_fanout(lvl);
            if (first >= lim) begin
                first = 0;
                cnt   = 0;
            end else if (first + cnt > lim) begin
                cnt = lim - first;
            end
        end
        return locate(lvl, lvl > 0, par, first, cnt);
    endfunction

    task automatic add_write(logic [mrtni_pkg::CFG_IDX_W-1:0] idx,
                             logic [mrtni_pkg::CFG_DATA_W-1:0] val);
        t_row row;
        row       = '{kind: ROW_WRITE, index: idx, value: val, rank: '0, typed: 1'b0,
                      want: '0};
        rows.push_back(row);
    endtask

    task automatic add_request(logic [mrtni_pkg::RANK_W-1:0] rank, bit typed, t_locate want);
        t_row row;
        row       = '{kind: ROW_REQUEST, index: '0, value: '0, rank: rank, typed: typed,
                      want: want};
        rows.push_back(row);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_locations.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_register(logic [mrtni_pkg::CFG_IDX_W-1:0] idx,
                                  logic [mrtni_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == mrtni_pkg::CFG_LEVEL_COUNT) begin
            cfg_levels = val[mrtni_pkg::LVL_W-1:0];
        end else if (idx <= mrtni_pkg::CFG_FANOUT_LAST) begin
            cfg_fanout[idx - mrtni_pkg::CFG_FANOUT_FIRST] = val;
        end
        @(posedge i_clk);
    endtask

    task automatic send_request(logic [mrtni_pkg::RANK_W-1:0] rank, bit typed,
                                t_locate want);
        while ($urandom_range(99, 0) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rank;
        do @(posedge i_clk); while (!s_tready);
        pending_locations.push_back(typed ? want : predict_location(rank));
    endtask

    task automatic report_field(string name, longint unsigned want, longint unsigned got);
        $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
        fail_count++;
    endtask

    task automatic check_location(t_locate got);
        t_locate want;
        want = pending_locations.pop_front();
        if (got.node_level !== want.node_level) begin
            report_field("node_level", want.node_level, got.node_level);
        end
        if (got.has_parent !== want.has_parent) begin
            report_field("has_parent", want.has_parent, got.has_parent);
        end
        if (got.parent_rank !== want.parent_rank) begin
            report_field("parent_rank", want.parent_rank, got.parent_rank);
        end
        if (got.first_child !== want.first_child) begin
            report_field("first_child", want.first_child, got.first_child);
        end
        if (got.child_count !== want.child_count) begin
            report_field("child_count", want.child_count, got.child_count);
        end
        if (got.status !== want.status) begin
            report_field("status", want.status, got.status);
        end
    endtask

    function automatic logic [mrtni_pkg::RANK_W-1:0] random_rank();
        longint unsigned lim;
        longint unsigned pick;
        int              lvl;
        lim  = tree_span();
        pick = $urandom_range(99, 0);
        if (pick < 60) begin
            return mrtni_pkg::RANK_W'($urandom_range(32'(lim - 1), 0));
        end else if (pick < 75) begin
            lvl = $urandom_range(int'(eff_levels()) - 1, 0);
            return mrtni_pkg::RANK_W'(level_start(lvl) + $urandom_range(2, 0) - 1);
        end else if (pick < 85) begin
            return mrtni_pkg::RANK_W'(lim + $urandom_range(3, 0) - 2);
        end
        return mrtni_pkg::RANK_W'($urandom());
    endfunction

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_locations.size() == 0) begin
                $display("%0t ns: result with nothing expected, actual %h", $time, m_tdata);
                fail_count++;
            end else begin
                check_location(t_locate'(m_tdata[$bits(t_locate)-1:0]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        cfg_levels = mrtni_pkg::RESET_LEVEL_COUNT;
        for (int i = 0; i < mrtni_pkg::FAN_REGS; i++) begin
            cfg_fanout[i] = mrtni_pkg::RESET_FANOUT;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: three levels of fan-out two, seven nodes.
        add_request(24'd0, 1'b1, locate(0, 1'b0, 0, 1, 2));
        add_request(24'd1, 1'b1, locate(1, 1'b1, 0, 3, 2));
        add_request(24'd2, 1'b0, '0);
        add_request(24'd6, 1'b1, locate(2, 1'b1, 2, 0, 0));
        add_request(24'd7, 1'b1, OFF_TREE);
        add_request(24'hFFFFFF, 1'b1, OFF_TREE);
        // Largest tree: it fills the rank width, so the deepest parents lose children.
        add_write(mrtni_pkg::CFG_LEVEL_COUNT, 5'd7);
        for (int i = 0; i < mrtni_pkg::FAN_REGS; i++) begin
            add_write(mrtni_pkg::CFG_FANOUT_FIRST + mrtni_pkg::CFG_IDX_W'(i), 5'd16);
        end
        add_request(24'd0, 1'b0, '0);
        add_request(24'd1048575, 1'b0, '0);
        add_request(24'd1048576, 1'b0, '0);
        add_request(24'd1118480, 1'b0, '0);
        add_request(24'd1118481, 1'b0, '0);
        add_request(24'hFFFFFF, 1'b0, '0);
        // Level count below the range and a zero fan-out: a root with one child.
        add_write(mrtni_pkg::CFG_LEVEL_COUNT, 5'd0);
        add_write(mrtni_pkg::CFG_FANOUT_FIRST, 5'd0);
        add_request(24'd0, 1'b1, locate(0, 1'b0, 0, 1, 1));
        add_request(24'd1, 1'b1, locate(1, 1'b1, 0, 0, 0));
        add_request(24'd2, 1'b1, OFF_TREE);
        // Fan-outs above the range, and a write to an index past the register list.
        add_write(mrtni_pkg::CFG_LEVEL_COUNT, 5'd15);
        add_write(mrtni_pkg::CFG_FANOUT_FIRST, 5'd31);
        add_write(mrtni_pkg::CFG_FANOUT_FIRST + 3'd1, 5'd0);
        add_write(mrtni_pkg::CFG_FANOUT_FIRST + 3'd2, 5'd3);
        add_write(mrtni_pkg::CFG_FANOUT_FIRST + 3'd3, 5'd1);
        add_write(mrtni_pkg::CFG_FANOUT_FIRST + 3'd4, 5'd17);
        add_write(mrtni_pkg::CFG_FANOUT_FIRST + 3'd5, 5'd5);
        add_write(CFG_UNUSED, 5'd1);
        add_request(24'd0, 1'b0, '0);
        add_request(24'd16, 1'b0, '0);
        add_request(24'd17, 1'b0, '0);
        add_request(24'd33, 1'b0, '0);
        add_request(24'd150, 1'b0, '0);

        settings_run = 1;
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_WRITE) begin
                if (i == 0 || rows[i-1].kind != ROW_WRITE) begin
                    wait_for_results();
                    settings_run++;
                end
                write_register(rows[i].index, rows[i].value);
            end else begin
                send_request(rows[i].rank, rows[i].typed, rows[i].want);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_results();
            case (phase % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 50;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 50;
                end
                default: begin
                    idle_pct  = 18;
                    stall_pct = 18;
                end
            endcase
            for (int idx = 0; idx <= mrtni_pkg::FAN_REGS; idx++) begin
                if (phase == 1) begin
                    write_register(mrtni_pkg::CFG_IDX_W'(idx),
                                   5'd16 - 5'(idx == 0) * 5'd9);
                end else if (phase == 3) begin
                    write_register(mrtni_pkg::CFG_IDX_W'(idx), (idx == 0) ? 5'd2 : 5'd1);
                end else if ($urandom_range(99, 0) < 70 && idx != 0) begin
                    write_register(mrtni_pkg::CFG_IDX_W'(idx), 5'($urandom_range(16, 1)));
                end else begin
                    write_register(mrtni_pkg::CFG_IDX_W'(idx), 5'($urandom_range(31, 0)));
                end
            end
            if (phase == 4) begin
                write_register(CFG_UNUSED, 5'($urandom_range(31, 0)));
            end
            settings_run++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 2 && n == PHASE_ITEMS / 2) begin
                    wait_for_results();
                end
                send_request(random_rank(), 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (4 * LATENCY) @(posedge i_clk);
        if (pending_locations.size() != 0) begin
            $display("%0t ns: %0d results never arrived", $time, pending_locations.size());
            fail_count++;
        end
        $display("Checked %0d results over %0d register settings, from the smallest tree",
                 results_seen, settings_run);
        $display("to the largest, with idle sender and stalling receiver phases.");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
